@@ sv/assert_macros.svh @@
// assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ sv/phsrl_pkg.sv @@
`default_nettype none
package phsrl_pkg;
  localparam int unsigned HostEntries  = 16;
  localparam int unsigned PendingDepth = 64;
  localparam int unsigned HostW  = $clog2(HostEntries);
  localparam int unsigned PendW  = $clog2(PendingDepth);

  localparam logic [1:0] ReqTick    = 2'd0;
  localparam logic [1:0] ReqCheck   = 2'd1;
  localparam logic [1:0] ReqInstall = 2'd2;
  localparam logic [1:0] ReqSpare   = 2'd3;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StUnknown = 2'd1;
  localparam logic [1:0] StOver    = 2'd2;
  localparam logic [1:0] StFull    = 2'd3;

  localparam logic [15:0] WindowReset = 16'd1000;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] host_ip;
    logic [7:0]  new_limit;
  } req_t;

  typedef struct packed {
    logic       allowed;
    logic [1:0] status;
    logic [7:0] current_count;
  } rsp_t;

  // classified item handed from front to back
  typedef struct packed {
    logic [1:0]       req_type;
    logic             hit;
    logic [HostW-1:0] hit_idx;
    logic             has_free;
    logic [HostW-1:0] free_idx;
    logic [31:0]      host_ip;
    logic [7:0]       new_limit;
  } cls_t;
endpackage
`default_nettype wire

@@ sv/phsrl_front.sv @@
`default_nettype none
`include "assert_macros.svh"
module phsrl_front (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire phsrl_pkg::req_t          in_data_i,
  input  wire logic [phsrl_pkg::HostEntries-1:0] valid_i,
  input  wire logic [phsrl_pkg::HostEntries-1:0][31:0] addr_i,
  input  wire logic                     busy_i,
  output logic                          q_valid_o,
  input  wire logic                     q_pop_i,
  output phsrl_pkg::cls_t               q_data_o
);
  // one item may be in the queue or back at a time, since lookups read table state
  phsrl_pkg::cls_t cls_q;
  logic            full_q, full_d;
  phsrl_pkg::cls_t cls_d;
  logic            take;

  assign in_stall = full_q || busy_i;
  assign take     = in_valid && !in_stall;

  always_comb begin
    cls_d           = '0;
    cls_d.req_type  = in_data_i.req_type;
    cls_d.host_ip   = in_data_i.host_ip;
    cls_d.new_limit = in_data_i.new_limit;
    for (int i = phsrl_pkg::HostEntries - 1; i >= 0; i--) begin
      if (valid_i[i] && addr_i[i] == in_data_i.host_ip) begin
        cls_d.hit     = 1'b1;
        cls_d.hit_idx = i[phsrl_pkg::HostW-1:0];
      end
      if (!valid_i[i]) begin
        cls_d.has_free = 1'b1;
        cls_d.free_idx = i[phsrl_pkg::HostW-1:0];
      end
    end
  end

  always_comb begin
    full_d = full_q;
    if (q_pop_i) full_d = 1'b0;
    if (take) full_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else begin
      full_q <= full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) cls_q <= cls_d;
  end

  assign q_valid_o = full_q;
  assign q_data_o  = cls_q;

  `ASSERT_IMPL(a_no_take_when_full, full_q, !take)
  `ASSERT_IMPL(a_pop_only_full, q_pop_i, full_q)
  `ASSERT_NEXT(a_take_fills, take, full_q)
endmodule
`default_nettype wire

@@ sv/phsrl_back.sv @@
`default_nettype none
`include "assert_macros.svh"
module phsrl_back (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic [15:0]              window_i,
  input  wire logic                     q_valid_i,
  output logic                          q_pop_o,
  input  wire phsrl_pkg::cls_t          q_data_i,
  output logic [phsrl_pkg::HostEntries-1:0] valid_o,
  output logic [phsrl_pkg::HostEntries-1:0][31:0] addr_o,
  output logic                          busy_o,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output phsrl_pkg::rsp_t               out_data_o
);
  typedef enum logic [1:0] {S_IDLE, S_RETIRE, S_EXP, S_OUT} state_e;
  localparam int unsigned PW = phsrl_pkg::PendW;
  localparam int unsigned HW = phsrl_pkg::HostW;

  state_e state_q;
  logic [phsrl_pkg::HostEntries-1:0]       valid_q;
  logic [phsrl_pkg::HostEntries-1:0][31:0] addr_q;
  logic [phsrl_pkg::HostEntries-1:0][7:0]  cnt_q;
  logic [phsrl_pkg::HostEntries-1:0][7:0]  lim_q;
  logic [HW-1:0] slot_mem [phsrl_pkg::PendingDepth];
  logic [31:0]   time_mem [phsrl_pkg::PendingDepth];
  logic [PW-1:0] head_q, tail_q;
  logic [PW:0]   fill_q;
  logic [31:0]   now_q;
  logic [HW-1:0] rd_slot_q;
  logic [31:0]   rd_time_q;
  phsrl_pkg::rsp_t rsp_q;
  logic [31:0]   diff;

  assign valid_o    = valid_q;
  assign addr_o     = addr_q;
  assign out_valid  = (state_q == S_OUT);
  assign out_data_o = rsp_q;
  assign busy_o     = (state_q != S_IDLE) || q_valid_i;
  assign q_pop_o    = (state_q == S_IDLE) && q_valid_i;
  assign diff       = now_q - rd_time_q;

  always_ff @(posedge clk_i) begin
    rd_slot_q <= slot_mem[head_q];
    rd_time_q <= time_mem[head_q];
    if (q_pop_o && q_data_i.req_type == phsrl_pkg::ReqCheck && q_data_i.hit
        && cnt_q[q_data_i.hit_idx] < lim_q[q_data_i.hit_idx]
        && fill_q < (PW+1)'(phsrl_pkg::PendingDepth)) begin
      slot_mem[tail_q] <= q_data_i.hit_idx;
      time_mem[tail_q] <= now_q + 32'(window_i);
    end
    if (q_pop_o && q_data_i.req_type == phsrl_pkg::ReqInstall) begin
      if (q_data_i.hit) begin
        lim_q[q_data_i.hit_idx] <= q_data_i.new_limit;
      end else if (q_data_i.has_free) begin
        addr_q[q_data_i.free_idx] <= q_data_i.host_ip;
        lim_q[q_data_i.free_idx]  <= q_data_i.new_limit;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= '0;
      cnt_q   <= '0;
      head_q  <= '0;
      tail_q  <= '0;
      fill_q  <= '0;
      now_q   <= '0;
      rsp_q   <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (q_valid_i) begin
            unique case (q_data_i.req_type)
              phsrl_pkg::ReqTick: begin
                rsp_q   <= '0;
                now_q   <= now_q + 32'd1;
                state_q <= S_RETIRE;
              end
              phsrl_pkg::ReqCheck: begin
                state_q <= S_OUT;
                if (!q_data_i.hit) begin
                  rsp_q <= '{allowed: 1'b0, status: phsrl_pkg::StUnknown,
                             current_count: 8'd0};
                end else if (cnt_q[q_data_i.hit_idx] >= lim_q[q_data_i.hit_idx]) begin
                  rsp_q <= '{allowed: 1'b0, status: phsrl_pkg::StOver,
                             current_count: cnt_q[q_data_i.hit_idx]};
                end else if (fill_q >= (PW+1)'(phsrl_pkg::PendingDepth)) begin
                  rsp_q <= '{allowed: 1'b0, status: phsrl_pkg::StFull,
                             current_count: cnt_q[q_data_i.hit_idx]};
                end else begin
                  cnt_q[q_data_i.hit_idx] <= cnt_q[q_data_i.hit_idx] + 8'd1;
                  rsp_q <= '{allowed: 1'b1, status: phsrl_pkg::StOk,
                             current_count: cnt_q[q_data_i.hit_idx] + 8'd1};
                  tail_q <= (tail_q == PW'(phsrl_pkg::PendingDepth - 1)) ? '0
                            : tail_q + 1'b1;
                  fill_q <= fill_q + 1'b1;
                end
              end
              phsrl_pkg::ReqInstall: begin
                state_q <= S_OUT;
                if (q_data_i.hit) begin
                  rsp_q <= '{allowed: 1'b0, status: phsrl_pkg::StOk,
                             current_count: cnt_q[q_data_i.hit_idx]};
                end else if (q_data_i.has_free) begin
                  rsp_q <= '0;
                  valid_q[q_data_i.free_idx] <= 1'b1;
                  cnt_q[q_data_i.free_idx]   <= '0;
                end else begin
                  rsp_q <= '{allowed: 1'b0, status: phsrl_pkg::StFull,
                             current_count: 8'd0};
                end
              end
              default: begin
                rsp_q   <= '0;
                state_q <= S_OUT;
              end
            endcase
          end
        end
        S_RETIRE: begin
          // memory read of head settles
          state_q <= S_EXP;
        end
        S_EXP: begin
          if (fill_q != '0 && !diff[31]) begin
            if (cnt_q[rd_slot_q] != 8'd0) cnt_q[rd_slot_q] <= cnt_q[rd_slot_q] - 8'd1;
            head_q <= (head_q == PW'(phsrl_pkg::PendingDepth - 1)) ? '0 : head_q + 1'b1;
            fill_q <= fill_q - 1'b1;
            state_q <= S_RETIRE;
          end else begin
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_stall) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `ASSERT_IMPL(a_fill_bound, 1'b1, fill_q <= (PW+1)'(phsrl_pkg::PendingDepth))
  `ASSERT_IMPL(a_allowed_ok, out_valid && rsp_q.allowed, rsp_q.status == phsrl_pkg::StOk)
  `ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(rsp_q))
endmodule
`default_nettype wire

@@ sv/per_host_sliding_rate_limiter_unit.sv @@
// channel  | handshake            | payload
// in       | in_valid / in_stall  | in_data_i  (req_type, host_ip, new_limit)
// out      | out_valid / out_stall| out_data_o (allowed, status, current_count)
// cfg      | cfg_we               | cfg_wdata (window_ticks)
// check and install: an accepted item is registered in the front queue, then the back
// unit registers its result; tick: the back unit passes S_RETIRE and S_EXP, again per
// retired expiry, paced by the registered read of the expiry memory head
// one item in flight; the next is taken once the result has been taken
// reset clears host valid marks, counts, queue pointers and time; window 1000
`default_nettype none
module per_host_sliding_rate_limiter_unit (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire phsrl_pkg::req_t   in_data_i,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output phsrl_pkg::rsp_t        out_data_o,
  input  wire logic              cfg_we,
  input  wire logic [15:0]       cfg_wdata
);
  logic [15:0] window_q;
  logic        q_valid, q_pop, busy;
  phsrl_pkg::cls_t q_data;
  logic [phsrl_pkg::HostEntries-1:0]       valid_v;
  logic [phsrl_pkg::HostEntries-1:0][31:0] addr_v;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= phsrl_pkg::WindowReset;
    end else if (cfg_we) begin
      window_q <= cfg_wdata;
    end
  end

  phsrl_front u_front (
    .clk_i, .rst_ni, .in_valid, .in_stall, .in_data_i,
    .valid_i(valid_v), .addr_i(addr_v), .busy_i(busy),
    .q_valid_o(q_valid), .q_pop_i(q_pop), .q_data_o(q_data)
  );

  phsrl_back u_back (
    .clk_i, .rst_ni, .window_i(window_q),
    .q_valid_i(q_valid), .q_pop_o(q_pop), .q_data_i(q_data),
    .valid_o(valid_v), .addr_o(addr_v), .busy_o(busy),
    .out_valid, .out_stall, .out_data_o
  );
endmodule
`default_nettype wire

@@ tb/tb.sv @@
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 2000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  phsrl_pkg::req_t in_data_i = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  phsrl_pkg::rsp_t out_data_o;
  logic cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;

  per_host_sliding_rate_limiter_unit u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid(in_valid), .in_stall(in_stall), .in_data_i(in_data_i),
    .out_valid(out_valid), .out_stall(out_stall), .out_data_o(out_data_o),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // limiter state mirror
  logic [15:0] win;
  logic        host_used [phsrl_pkg::HostEntries];
  logic [31:0] host_addr [phsrl_pkg::HostEntries];
  logic [7:0]  host_cnt [phsrl_pkg::HostEntries];
  logic [7:0]  host_lim [phsrl_pkg::HostEntries];
  logic [phsrl_pkg::HostW-1:0] pend_host [$];
  logic [31:0] pend_due [$];
  logic [31:0] now_t;

  phsrl_pkg::rsp_t verdicts [$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  bit hold_off = 1'b0;
  bit no_stall = 1'b0;
  logic [31:0] known [$];

  function automatic int lookup_host(logic [31:0] ip);
    for (int i = 0; i < phsrl_pkg::HostEntries; i++)
      if (host_used[i] && host_addr[i] == ip) return i;
    return -1;
  endfunction

  function automatic phsrl_pkg::rsp_t rate_verdict(phsrl_pkg::req_t r);
    phsrl_pkg::rsp_t v;
    int h;
    v = '0;
    case (r.req_type)
      phsrl_pkg::ReqTick: begin
        now_t = now_t + 32'd1;
        while (pend_due.size() > 0 && (now_t - pend_due[0]) < 32'h8000_0000) begin
          if (host_cnt[pend_host[0]] > 0) host_cnt[pend_host[0]]--;
          void'(pend_host.pop_front());
          void'(pend_due.pop_front());
        end
      end
      phsrl_pkg::ReqCheck: begin
        h = lookup_host(r.host_ip);
        if (h < 0) v.status = phsrl_pkg::StUnknown;
        else if (host_cnt[h] >= host_lim[h]) begin
          v.status = phsrl_pkg::StOver;
          v.current_count = host_cnt[h];
        end else if (pend_due.size() >= phsrl_pkg::PendingDepth) begin
          v.status = phsrl_pkg::StFull;
          v.current_count = host_cnt[h];
        end else begin
          host_cnt[h]++;
          pend_host.push_back(h[phsrl_pkg::HostW-1:0]);
          pend_due.push_back(now_t + {16'd0, win});
          v.allowed = 1'b1;
          v.current_count = host_cnt[h];
        end
      end
      phsrl_pkg::ReqInstall: begin
        h = lookup_host(r.host_ip);
        if (h >= 0) begin
          host_lim[h] = r.new_limit;
          v.current_count = host_cnt[h];
        end else begin
          h = -1;
          for (int i = phsrl_pkg::HostEntries - 1; i >= 0; i--) if (!host_used[i]) h = i;
          if (h < 0) v.status = phsrl_pkg::StFull;
          else begin
            host_used[h] = 1'b1;
            host_addr[h] = r.host_ip;
            host_cnt[h] = '0;
            host_lim[h] = r.new_limit;
          end
        end
      end
      default: ;
    endcase
    return v;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    phsrl_pkg::rsp_t want;
    cycles <= cycles + 1;
    if (rst_ni && out_valid && !out_stall) begin
      if (verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_data_o);
      end else begin
        want = verdicts.pop_front();
        if (want.allowed !== out_data_o.allowed || want.status !== out_data_o.status ||
            want.current_count !== out_data_o.current_count) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %p actual %p", want, out_data_o);
        end
      end
    end
  end

  // receiver stall pattern
  always @(negedge clk_i) begin
    int unsigned ph;
    ph = (cycles / 64) % 4;
    if (hold_off) out_stall <= 1'b1;
    else if (no_stall || ph == 0) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 3) < ph);
  end

  always @(posedge clk_i) begin
    if (cycles >= CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  int unsigned burst_left = 0;

  // valid stays high within a burst and drops only in gaps or when idle
  task automatic send_item(phsrl_pkg::req_t r);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data_i <= r;
    verdicts.push_back(rate_verdict(r));
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    while (verdicts.size() != 0) @(negedge clk_i);
    repeat (3 * 2 * phsrl_pkg::PendingDepth + 20) @(negedge clk_i);
  endtask

  task automatic set_window(logic [15:0] w);
    drain();
    @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_wdata <= w;
    win = w;
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  function automatic phsrl_pkg::req_t mk(logic [1:0] t, logic [31:0] ip, logic [7:0] lim);
    phsrl_pkg::req_t r;
    r.req_type = t;
    r.host_ip = ip;
    r.new_limit = lim;
    return r;
  endfunction

  task automatic test_directed();
    send_item(mk(phsrl_pkg::ReqCheck, 32'd99, 8'd0));
    send_item(mk(phsrl_pkg::ReqInstall, 32'd99, 8'd2));
    send_item(mk(phsrl_pkg::ReqInstall, 32'hFFFF_FFFF, 8'hFF));
    send_item(mk(phsrl_pkg::ReqInstall, 32'd0, 8'd0));
    send_item(mk(phsrl_pkg::ReqCheck, 32'd0, 8'hFF));
    for (int i = 0; i < 3; i++) send_item(mk(phsrl_pkg::ReqCheck, 32'd99, 8'd0));
    send_item(mk(phsrl_pkg::ReqInstall, 32'd99, 8'd3));
    send_item(mk(phsrl_pkg::ReqCheck, 32'd99, 8'd0));
    send_item(mk(phsrl_pkg::ReqCheck, 32'hFFFF_FFFF, 8'd0));
    send_item(mk(phsrl_pkg::ReqSpare, 32'hA5A5_5A5A, 8'hAA));
    send_item(mk(phsrl_pkg::ReqTick, 32'hFFFF_FFFF, 8'hFF));
    send_item(mk(phsrl_pkg::ReqTick, 32'd0, 8'd0));
  endtask

  task automatic test_window_extremes();
    set_window(16'd0);
    for (int i = 0; i < 4; i++) send_item(mk(phsrl_pkg::ReqCheck, 32'hFFFF_FFFF, 8'd0));
    send_item(mk(phsrl_pkg::ReqTick, 32'd0, 8'd0));
    send_item(mk(phsrl_pkg::ReqCheck, 32'hFFFF_FFFF, 8'd0));
    set_window(16'd5);
    for (int i = 0; i < 3; i++) send_item(mk(phsrl_pkg::ReqCheck, 32'hFFFF_FFFF, 8'd0));
    set_window(16'd1);
    send_item(mk(phsrl_pkg::ReqCheck, 32'd99, 8'd0));
    for (int i = 0; i < 6; i++) send_item(mk(phsrl_pkg::ReqTick, 32'd0, 8'd0));
    set_window(16'hFFFF);
    send_item(mk(phsrl_pkg::ReqCheck, 32'hFFFF_FFFF, 8'd0));
  endtask

  task automatic test_table_full();
    for (int i = 0; i < phsrl_pkg::HostEntries + 2; i++)
      send_item(mk(phsrl_pkg::ReqInstall, 32'h0A00_0000 + i,
                   8'($urandom_range(0, 255))));
    send_item(mk(phsrl_pkg::ReqInstall, 32'hFFFF_FFFF, 8'd40));
  endtask

  task automatic test_queue_full();
    // long receiver hold-off while items keep coming
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(negedge clk_i);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 80; i++)
        send_item(mk(phsrl_pkg::ReqCheck, (i % 2) ? 32'hFFFF_FFFF : 32'h0A00_0001, 8'd0));
    join
    drain();
    send_item(mk(phsrl_pkg::ReqTick, 32'd0, 8'd0));
  endtask

  task automatic test_random(int unsigned n);
    phsrl_pkg::req_t r;
    int unsigned k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      if (k < 45) r = mk(phsrl_pkg::ReqCheck, known[$urandom_range(0, known.size() - 1)],
                         8'($urandom()));
      else if (k < 75) r = mk(phsrl_pkg::ReqTick, $urandom(), 8'($urandom()));
      else if (k < 85) r = mk(phsrl_pkg::ReqInstall,
                             known[$urandom_range(0, known.size() - 1)],
                             8'($urandom_range(0, 8)));
      else if (k < 95) r = mk(2'($urandom_range(0, 3)), $urandom(), 8'($urandom()));
      else r = mk(phsrl_pkg::ReqInstall, $urandom(), 8'($urandom()));
      send_item(r);
    end
  endtask

  initial begin
    win = phsrl_pkg::WindowReset;
    now_t = '0;
    for (int i = 0; i < phsrl_pkg::HostEntries; i++) begin
      host_used[i] = 1'b0;
      host_cnt[i] = '0;
      host_addr[i] = '0;
      host_lim[i] = '0;
    end
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_window_extremes();
    test_table_full();
    test_queue_full();
    for (int i = 0; i < phsrl_pkg::HostEntries; i++) known.push_back(host_addr[i]);
    known.push_back(32'hDEAD_BEEF);
    set_window(16'd3);
    no_stall = 1'b1;
    test_random(350);
    no_stall = 1'b0;
    drain();
    set_window(16'd20);
    test_random(350);
    set_window(16'd2);
    test_random(300);
    drain();
    if (mismatches == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule
`default_nettype wire

@@ per_host_sliding_rate_limiter_unit.f @@
+incdir+sv
sv/phsrl_pkg.sv
sv/phsrl_front.sv
sv/phsrl_back.sv
sv/per_host_sliding_rate_limiter_unit.sv
tb/tb.sv
